@@ hw/rtl/pbcc_pkg.sv @@
`default_nettype none

package pbcc_pkg;

    // Field widths
    localparam int POS_W   = 16;
    localparam int DIM_W   = 15;
    localparam int SEQ_W   = 16;
    localparam int CODE_W  = 5;
    localparam int HITS_W  = 6;
    localparam int TOTAL_W = 16;
    localparam int TOL_W   = 8;

    // Bounds are in half-millimetres; thresholds carry one more bit for the slack
    localparam int COORD_W = 18;
    localparam int THR_W   = 19;

    // Orientation codes
    localparam logic [CODE_W-1:0] ORIENT_MIN  = 5'd1;
    localparam logic [CODE_W-1:0] ORIENT_MAX  = 5'd24;
    localparam logic [CODE_W-1:0] ORIENT_HALF = 5'd12;

    // Result kinds
    localparam logic KIND_HIT     = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [1:0] {
        DIM_LEN,
        DIM_WID,
        DIM_HGT
    } dim_sel_t;

    typedef struct packed {
        logic     ok;
        dim_sel_t sx;
        dim_sel_t sy;
        dim_sel_t sz;
    } axes_t;

    typedef struct packed {
        logic                     first_of_pallet;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [POS_W-1:0]  pos_z;
        logic [DIM_W-1:0]         box_length;
        logic [DIM_W-1:0]         box_width;
        logic [DIM_W-1:0]         box_height;
        logic [CODE_W-1:0]        orientation;
        logic [SEQ_W-1:0]         seq_num;
    } box_req_t;

    typedef struct packed {
        logic               kind;
        logic [SEQ_W-1:0]   hit_seq;
        logic [HITS_W-1:0]  box_hits;
        logic [TOTAL_W-1:0] stack_total;
        logic               orient_error;
        logic               store_full;
        logic               is_last;
    } result_t;

    typedef struct packed {
        logic [TOL_W-1:0] tolerance;
    } cfg_req_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] min_x;
        logic signed [COORD_W-1:0] max_x;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] max_y;
        logic signed [COORD_W-1:0] min_z;
        logic signed [COORD_W-1:0] max_z;
        logic [SEQ_W-1:0]          seq;
    } entry_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic calc;
        logic thresh;
        logic idx_clear;
        logic idx_step;
        logic emit_hit;
        logic hit_pallet;
        logic emit_sum;
    } pbcc_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic slot_free;
        logic orient_bad;
        logic pallet_hit;
        logic entry_hit;
        logic scan_done;
    } pbcc_sts_t;

    // Map an orientation code to the article dimension on each axis
    function automatic axes_t orient_axes(input logic [CODE_W-1:0] code);
        logic [CODE_W-1:0] c;
        logic [CODE_W-1:0] m;
        logic [2:0]        grp;
        axes_t             a;
        c     = code - ORIENT_MIN;
        m     = (c >= ORIENT_HALF) ? (c - ORIENT_HALF) : c;
        grp   = {m[3:2], 1'b0} + {2'b00, m[0]};
        a.ok  = (code >= ORIENT_MIN) && (code <= ORIENT_MAX);
        case (grp)
            3'd0:    begin a.sx = DIM_LEN; a.sy = DIM_WID; a.sz = DIM_HGT; end
            3'd1:    begin a.sx = DIM_WID; a.sy = DIM_LEN; a.sz = DIM_HGT; end
            3'd2:    begin a.sx = DIM_LEN; a.sy = DIM_HGT; a.sz = DIM_WID; end
            3'd3:    begin a.sx = DIM_HGT; a.sy = DIM_LEN; a.sz = DIM_WID; end
            3'd4:    begin a.sx = DIM_HGT; a.sy = DIM_WID; a.sz = DIM_LEN; end
            3'd5:    begin a.sx = DIM_WID; a.sy = DIM_HGT; a.sz = DIM_LEN; end
            default: begin a.sx = DIM_LEN; a.sy = DIM_WID; a.sz = DIM_HGT; end
        endcase
        return a;
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim(
        input logic [DIM_W-1:0] len,
        input logic [DIM_W-1:0] wid,
        input logic [DIM_W-1:0] hgt,
        input dim_sel_t         sel
    );
        logic [DIM_W-1:0] d;
        case (sel)
            DIM_LEN: d = len;
            DIM_WID: d = wid;
            DIM_HGT: d = hgt;
            default: d = len;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/pbcc_stream_if.sv @@
`default_nettype none

interface pbcc_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/pbcc_ctrl.sv @@
`default_nettype none

module pbcc_ctrl
    import pbcc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire pbcc_sts_t sts,
    output pbcc_cmd_t      cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BOUNDS,
        S_THRESH,
        S_PALLET,
        S_SCAN,
        S_SUMMARY
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;

    // Sequence one box: load, bounds, thresholds, pallet check, scan, summary (a bad code skips to the summary)
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_BOUNDS;
                end
            end
            S_BOUNDS:
            begin
                cmd.calc      = 1'b1;
                cmd.idx_clear = 1'b1;
                state_next    = S_THRESH;
            end
            S_THRESH:
            begin
                cmd.thresh = 1'b1;
                state_next = S_PALLET;
            end
            S_PALLET:
            begin
                if (sts.orient_bad)
                begin
                    state_next = S_SUMMARY;
                end
                else if (!sts.pallet_hit)
                begin
                    state_next = S_SCAN;
                end
                else if (sts.slot_free)
                begin
                    cmd.emit_hit   = 1'b1;
                    cmd.hit_pallet = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = S_SUMMARY;
                end
                else if (!sts.entry_hit)
                begin
                    cmd.idx_step = 1'b1;
                end
                else if (sts.slot_free)
                begin
                    cmd.emit_hit = 1'b1;
                    cmd.idx_step = 1'b1;
                end
            end
            S_SUMMARY:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit_sum = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and the input ready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= (state_next == S_IDLE);
        end
    end

    assign in_ready = in_ready_reg;

    // A bad orientation code never produces hit reports
    ap_no_hit_bad_orient: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_hit |-> !sts.orient_bad)
        else $error("hit report issued for a bad orientation");

    // After the summary the controller is free for the next request
    ap_idle_after_sum: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_sum |=> (in_ready && state_reg == S_IDLE))
        else $error("controller not idle after summary");

endmodule

`default_nettype wire

@@ hw/rtl/pbcc_dp.sv @@
`default_nettype none

module pbcc_dp
    import pbcc_pkg::*;
#(
    parameter int MAX_BOXES = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire pbcc_cmd_t        cmd,
    output pbcc_sts_t             sts,
    input  wire box_req_t         in_data,
    input  wire logic             cfg_valid,
    input  wire logic [TOL_W-1:0] cfg_tolerance,
    output logic                  out_valid,
    output result_t               out_data,
    input  wire logic             out_ready
);

    localparam int CNT_W = $clog2(MAX_BOXES + 1);
    localparam int AW    = $clog2(MAX_BOXES);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BOXES);

    logic [TOL_W-1:0]          tol_reg;
    box_req_t                  box_reg;
    logic                      orient_bad_reg;
    logic signed [COORD_W-1:0] mnx_reg, mxx_reg, mny_reg, mxy_reg, mnz_reg, mxz_reg;
    logic signed [THR_W-1:0]   hi_x_reg, lo_x_reg, hi_y_reg, lo_y_reg, hi_z_reg, lo_z_reg;
    logic signed [THR_W-1:0]   lo_z_next;
    logic                      pallet_hit_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          idx_reg;
    logic [CNT_W-1:0]          idx_next;
    logic [HITS_W-1:0]         hits_reg;
    logic [TOTAL_W-1:0]        total_reg;
    logic [TOTAL_W-1:0]        total_next;
    logic [TOTAL_W:0]          total_sum;
    logic                      out_valid_reg;
    result_t                   out_data_reg;
    result_t                   out_data_next;
    entry_t                    rd_entry_reg;
    entry_t                    wr_entry;
    entry_t                    store_mem [MAX_BOXES];
    logic                      store_full;
    logic                      store_we;
    axes_t                     axes;
    logic [DIM_W-1:0]          dx, dy, dz;
    logic [COORD_W-1:0]        px2, py2, pz2;
    logic signed [THR_W-1:0]   tol_ext;
    logic                      apart;

    // Take the tolerance register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= '0;
        end
        else if (cfg_valid)
        begin
            tol_reg <= cfg_tolerance;
        end
    end

    // Select the dimension on each axis and double the positions
    always_comb
    begin
        axes = orient_axes(box_reg.orientation);
        dx   = pick_dim(box_reg.box_length, box_reg.box_width, box_reg.box_height, axes.sx);
        dy   = pick_dim(box_reg.box_length, box_reg.box_width, box_reg.box_height, axes.sy);
        dz   = pick_dim(box_reg.box_length, box_reg.box_width, box_reg.box_height, axes.sz);
        px2  = {box_reg.pos_x[POS_W-1], box_reg.pos_x, 1'b0};
        py2  = {box_reg.pos_y[POS_W-1], box_reg.pos_y, 1'b0};
        pz2  = {box_reg.pos_z[POS_W-1], box_reg.pos_z, 1'b0};
    end

    assign tol_ext   = $signed({{(THR_W - TOL_W){1'b0}}, tol_reg});
    assign lo_z_next = $signed({mnz_reg[COORD_W-1], mnz_reg}) + tol_ext;

    // Latch the request, form bounds, then the slack-adjusted thresholds
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            box_reg <= in_data;
        end
        if (cmd.calc)
        begin
            orient_bad_reg <= !axes.ok;
            mnx_reg <= $signed(px2 - {{(COORD_W - DIM_W){1'b0}}, dx});
            mxx_reg <= $signed(px2 + {{(COORD_W - DIM_W){1'b0}}, dx});
            mny_reg <= $signed(py2 - {{(COORD_W - DIM_W){1'b0}}, dy});
            mxy_reg <= $signed(py2 + {{(COORD_W - DIM_W){1'b0}}, dy});
            mnz_reg <= $signed(pz2 - {{(COORD_W - DIM_W - 1){1'b0}}, dz, 1'b0});
            mxz_reg <= $signed(pz2);
        end
        if (cmd.thresh)
        begin
            hi_x_reg       <= $signed({mxx_reg[COORD_W-1], mxx_reg}) - tol_ext;
            lo_x_reg       <= $signed({mnx_reg[COORD_W-1], mnx_reg}) + tol_ext;
            hi_y_reg       <= $signed({mxy_reg[COORD_W-1], mxy_reg}) - tol_ext;
            lo_y_reg       <= $signed({mny_reg[COORD_W-1], mny_reg}) + tol_ext;
            hi_z_reg       <= $signed({mxz_reg[COORD_W-1], mxz_reg}) - tol_ext;
            lo_z_reg       <= lo_z_next;
            pallet_hit_reg <= lo_z_next[THR_W-1];
        end
    end

    // Test the stored box read out for the current scan index
    always_comb
    begin
        apart = ($signed({rd_entry_reg.min_x[COORD_W-1], rd_entry_reg.min_x}) >= hi_x_reg)
             || ($signed({rd_entry_reg.max_x[COORD_W-1], rd_entry_reg.max_x}) <= lo_x_reg)
             || ($signed({rd_entry_reg.min_y[COORD_W-1], rd_entry_reg.min_y}) >= hi_y_reg)
             || ($signed({rd_entry_reg.max_y[COORD_W-1], rd_entry_reg.max_y}) <= lo_y_reg)
             || ($signed({rd_entry_reg.min_z[COORD_W-1], rd_entry_reg.min_z}) >= hi_z_reg)
             || ($signed({rd_entry_reg.max_z[COORD_W-1], rd_entry_reg.max_z}) <= lo_z_reg);
    end

    // Advance the scan index; the read address runs one step ahead
    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.idx_clear)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_step)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    // Saturate the running total
    assign total_sum  = {1'b0, total_reg} + {{(TOTAL_W + 1 - HITS_W){1'b0}}, hits_reg};
    assign total_next = total_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : total_sum[TOTAL_W-1:0];

    assign store_full = (count_reg == MAX_CNT);
    assign store_we   = cmd.emit_sum && !orient_bad_reg && !store_full;

    always_comb
    begin
        wr_entry.min_x = mnx_reg;
        wr_entry.max_x = mxx_reg;
        wr_entry.min_y = mny_reg;
        wr_entry.max_y = mxy_reg;
        wr_entry.min_z = mnz_reg;
        wr_entry.max_z = mxz_reg;
        wr_entry.seq   = box_reg.seq_num;
    end

    // Box store: one write, one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_mem[count_reg[AW-1:0]] <= wr_entry;
        end
        rd_entry_reg <= store_mem[idx_next[AW-1:0]];
    end

    // Counters: fill count, scan index, hits, total
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
            hits_reg  <= '0;
            total_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (cmd.load)
            begin
                hits_reg <= '0;
                if (in_data.first_of_pallet)
                begin
                    count_reg <= '0;
                    total_reg <= '0;
                end
            end
            if (cmd.emit_hit)
            begin
                hits_reg <= hits_reg + 1'b1;
            end
            if (cmd.emit_sum)
            begin
                total_reg <= total_next;
            end
            if (store_we)
            begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    // Output register: drop on take, load on emit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_hit || cmd.emit_sum)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Form the next result: a hit report or the summary
    always_comb
    begin
        out_data_next = '0;
        if (cmd.emit_hit)
        begin
            out_data_next.kind    = KIND_HIT;
            out_data_next.hit_seq = cmd.hit_pallet ? '0 : rd_entry_reg.seq;
        end
        else
        begin
            out_data_next.kind         = KIND_SUMMARY;
            out_data_next.box_hits     = hits_reg;
            out_data_next.stack_total  = total_next;
            out_data_next.orient_error = orient_bad_reg;
            out_data_next.store_full   = !orient_bad_reg && store_full;
            out_data_next.is_last      = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_hit || cmd.emit_sum)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        sts.slot_free  = !out_valid_reg || out_ready;
        sts.orient_bad = orient_bad_reg;
        sts.pallet_hit = pallet_hit_reg;
        sts.entry_hit  = !apart;
        sts.scan_done  = (idx_reg == count_reg);
    end

    // The fill count never passes the store depth
    ap_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("store count beyond depth");

    // Hits so far never exceed the pallet plus the boxes scanned
    ap_hits_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(hits_reg) <= int'(idx_reg) + 1)
        else $error("hit count ahead of scan");

endmodule

`default_nettype wire

@@ hw/rtl/placed_box_collision_check.sv @@
`default_nettype none
// Placed box collision check: one box request in, its hit reports and a summary out.
// After a request is taken it forms bounds and thresholds, checks the pallet, scans
// the stored boxes and registers the summary; a bad orientation code skips the pallet
// check and scan. Hit reports come one per cycle while the output is not stalled. A new
// box is taken only after the summary of the last one; the scan walks the single read
// port one entry a cycle unless a hit waits on a stalled output. Reset clears the fill
// count, total, tolerance and handshakes; store contents are undefined until written.

module placed_box_collision_check
    import pbcc_pkg::*;
#(
    parameter int MAX_BOXES = 32
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    pbcc_stream_if.sink   cfg,
    pbcc_stream_if.sink   box_in,
    pbcc_stream_if.source result_out
);

    pbcc_cmd_t cmd;
    pbcc_sts_t sts;
    result_t   res_data;
    logic      res_valid;
    logic      in_ready;

    assign cfg.ready       = 1'b1;
    assign box_in.ready    = in_ready;
    assign result_out.valid = res_valid;
    assign result_out.data  = res_data;

    pbcc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (box_in.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pbcc_dp #(
        .MAX_BOXES (MAX_BOXES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .in_data       (box_in.data),
        .cfg_valid     (cfg.valid),
        .cfg_tolerance (cfg.data.tolerance),
        .out_valid     (res_valid),
        .out_data      (res_data),
        .out_ready     (result_out.ready)
    );

endmodule

`default_nettype wire

@@ sim/pbcc_collision_monitor.sv @@
`timescale 1ns / 1ps

module pbcc_collision_monitor
    import pbcc_pkg::*;
#(
    parameter int MAX_BOXES = 32
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     cfg_valid,
    input  wire logic     cfg_ready,
    input  wire cfg_req_t cfg_data,
    input  wire logic     box_valid,
    input  wire logic     box_ready,
    input  wire box_req_t box_data,
    input  wire logic     res_valid,
    input  wire logic     res_ready,
    input  wire result_t  res_data,
    output int            results_pending,
    output int            mismatches
);

    localparam int TOTAL_SAT = 65535;

    // Shadow of the tolerance register and the placed-box store
    logic [TOL_W-1:0]          slack = '0;
    logic signed [COORD_W-1:0] lo_x [MAX_BOXES];
    logic signed [COORD_W-1:0] hi_x [MAX_BOXES];
    logic signed [COORD_W-1:0] lo_y [MAX_BOXES];
    logic signed [COORD_W-1:0] hi_y [MAX_BOXES];
    logic signed [COORD_W-1:0] lo_z [MAX_BOXES];
    logic signed [COORD_W-1:0] hi_z [MAX_BOXES];
    logic [SEQ_W-1:0]          placed_seq [MAX_BOXES];
    int                        placed_count = 0;
    int                        stack_sum = 0;

    // Results owed by the block, oldest first
    result_t due_results [$];

    initial
    begin
        mismatches      = 0;
        results_pending = 0;
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Queue one owed result behind the others
    task automatic owe_result(input result_t r);
        due_results = {due_results, r};
    endtask

    // Work out the hit reports and summary that one box request causes
    task automatic predict_box_results(input box_req_t b);
        int      ext [3];
        int      lx, hx, ly, hy, lz, hz;
        int      tol;
        int      grp;
        int      n_hits;
        bit      apart;
        result_t r;

        if (b.first_of_pallet)
        begin
            placed_count = 0;
            stack_sum    = 0;
        end
        tol = int'(slack);

        // Bad orientation: summary only, nothing stored
        if (b.orientation < ORIENT_MIN || b.orientation > ORIENT_MAX)
        begin
            r              = '0;
            r.kind         = KIND_SUMMARY;
            r.stack_total  = TOTAL_W'(stack_sum);
            r.orient_error = 1'b1;
            r.is_last      = 1'b1;
            owe_result(r);
            return;
        end

        // Pick the article dimension lying along X, Y and Z
        grp = (int'(b.orientation) - int'(ORIENT_MIN)) % int'(ORIENT_HALF);
        case (grp)
            0, 2:    ext = '{int'(b.box_length), int'(b.box_width), int'(b.box_height)};
            1, 3:    ext = '{int'(b.box_width), int'(b.box_length), int'(b.box_height)};
            4, 6:    ext = '{int'(b.box_length), int'(b.box_height), int'(b.box_width)};
            5, 7:    ext = '{int'(b.box_height), int'(b.box_length), int'(b.box_width)};
            8, 10:   ext = '{int'(b.box_height), int'(b.box_width), int'(b.box_length)};
            default: ext = '{int'(b.box_width), int'(b.box_height), int'(b.box_length)};
        endcase

        // Bounds in half-millimetres
        lx = 2 * int'($signed(b.pos_x)) - ext[0];
        hx = 2 * int'($signed(b.pos_x)) + ext[0];
        ly = 2 * int'($signed(b.pos_y)) - ext[1];
        hy = 2 * int'($signed(b.pos_y)) + ext[1];
        hz = 2 * int'($signed(b.pos_z));
        lz = hz - 2 * ext[2];

        n_hits = 0;
        r      = '0;
        r.kind = KIND_HIT;

        // Pallet first, then stored boxes in placement order
        if (lz < -tol)
        begin
            r.hit_seq = '0;
            owe_result(r);
            n_hits++;
        end
        for (int j = 0; j < placed_count; j++)
        begin
            apart = (int'(lo_x[j]) >= hx - tol) || (int'(hi_x[j]) <= lx + tol) ||
                    (int'(lo_y[j]) >= hy - tol) || (int'(hi_y[j]) <= ly + tol) ||
                    (int'(lo_z[j]) >= hz - tol) || (int'(hi_z[j]) <= lz + tol);
            if (!apart)
            begin
                r.hit_seq = placed_seq[j];
                owe_result(r);
                n_hits++;
            end
        end

        stack_sum = stack_sum + n_hits;
        if (stack_sum > TOTAL_SAT)
            stack_sum = TOTAL_SAT;

        r             = '0;
        r.kind        = KIND_SUMMARY;
        r.box_hits    = HITS_W'(n_hits);
        r.stack_total = TOTAL_W'(stack_sum);
        r.is_last     = 1'b1;

        // Append the box, or flag it when the store is full
        if (placed_count < MAX_BOXES)
        begin
            lo_x[placed_count]       = COORD_W'(lx);
            hi_x[placed_count]       = COORD_W'(hx);
            lo_y[placed_count]       = COORD_W'(ly);
            hi_y[placed_count]       = COORD_W'(hy);
            lo_z[placed_count]       = COORD_W'(lz);
            hi_z[placed_count]       = COORD_W'(hz);
            placed_seq[placed_count] = b.seq_num;
            placed_count++;
        end
        else
        begin
            r.store_full = 1'b1;
        end
        owe_result(r);
    endtask

    // Compare results, track the register and predict on each accepted request
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (res_valid && res_ready)
            begin
                if (due_results.size() == 0)
                begin
                    $error("result with none pending: kind %0d hit_seq %0d",
                           res_data.kind, res_data.hit_seq);
                    mismatches++;
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("kind", want.kind, res_data.kind);
                    check_field("hit_seq", want.hit_seq, res_data.hit_seq);
                    check_field("box_hits", want.box_hits, res_data.box_hits);
                    check_field("stack_total", want.stack_total, res_data.stack_total);
                    check_field("orient_error", want.orient_error, res_data.orient_error);
                    check_field("store_full", want.store_full, res_data.store_full);
                    check_field("is_last", want.is_last, res_data.is_last);
                end
            end
            if (cfg_valid && cfg_ready)
                slack = cfg_data.tolerance;
            if (box_valid && box_ready)
                predict_box_results(box_data);
            results_pending = due_results.size();
        end
    end

endmodule

@@ sim/placed_box_collision_check_tb.sv @@
`timescale 1ns / 1ps

module placed_box_collision_check_tb;
    import pbcc_pkg::*;

    localparam int STORE_DEPTH  = 32;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 2 * STORE_DEPTH + 20;
    localparam int PHASE_ITEMS  = 40;
    localparam int PILE_BOXES   = 100;

    logic clk;
    logic rst_n;
    int   results_pending;
    int   mismatches;
    int   idle_cycles = 0;
    int   burst_left = 0;
    int   ready_left = 0;
    int   ready_mode = 0;

    pbcc_stream_if #(.payload_t(cfg_req_t)) cfg_if ();
    pbcc_stream_if #(.payload_t(box_req_t)) box_if ();
    pbcc_stream_if #(.payload_t(result_t))  res_if ();

    placed_box_collision_check #(
        .MAX_BOXES (STORE_DEPTH)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_if),
        .box_in     (box_if),
        .result_out (res_if)
    );

    pbcc_collision_monitor #(
        .MAX_BOXES (STORE_DEPTH)
    ) i_monitor (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_if.valid),
        .cfg_ready       (cfg_if.ready),
        .cfg_data        (cfg_if.data),
        .box_valid       (box_if.valid),
        .box_ready       (box_if.ready),
        .box_data        (box_if.data),
        .res_valid       (res_if.valid),
        .res_ready       (res_if.ready),
        .res_data        (res_if.data),
        .results_pending (results_pending),
        .mismatches      (mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (cfg_if.valid && cfg_if.ready) || (box_if.valid && box_if.ready) ||
            (res_if.valid && res_if.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Stall the result side: always ready, half ready or mostly stalled, in stretches
    always @(posedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_mode <= $urandom_range(0, 2);
            ready_left <= $urandom_range(10, 150);
        end
        else
            ready_left <= ready_left - 1;
        case (ready_mode)
            0:       res_if.ready <= 1'b1;
            1:       res_if.ready <= 1'($urandom_range(0, 1));
            default: res_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    function automatic box_req_t mk_box(input bit first, input int x, input int y,
                                        input int z, input int len, input int wid,
                                        input int hgt, input int code, input int seq);
        box_req_t b;
        b.first_of_pallet = first;
        b.pos_x           = POS_W'(x);
        b.pos_y           = POS_W'(y);
        b.pos_z           = POS_W'(z);
        b.box_length      = DIM_W'(len);
        b.box_width       = DIM_W'(wid);
        b.box_height      = DIM_W'(hgt);
        b.orientation     = CODE_W'(code);
        b.seq_num         = SEQ_W'(seq);
        return b;
    endfunction

    // Article size on a coarse grid, sometimes off grid
    function automatic int rand_size();
        int s;
        s = int'($urandom_range(1, 12)) * 50;
        if ($urandom_range(0, 3) == 0)
            s = s + int'($urandom_range(0, 160));
        return s;
    endfunction

    // Position on a coarse grid so faces often touch, sometimes jittered
    function automatic int rand_place(input int base);
        int p;
        p = int'($urandom_range(0, 24)) * 50 + base;
        if ($urandom_range(0, 3) == 0)
            p = p + int'($urandom_range(0, 130)) - 65;
        return p;
    endfunction

    // Plausible box of a stacking sequence
    function automatic box_req_t pallet_box(input bit first);
        int code;
        int seq;
        code = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 24);
        seq  = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(0, 65535);
        return mk_box(first, rand_place(-100), rand_place(-100), rand_place(0),
                      rand_size(), rand_size(), rand_size(), code, seq);
    endfunction

    // Fully random request
    function automatic box_req_t noise_box();
        logic [127:0] raw;
        box_req_t     b;
        raw = {$urandom, $urandom, $urandom, $urandom};
        b   = raw[$bits(box_req_t)-1:0];
        return b;
    endfunction

    // Offer one request, with a random gap between bursts
    task automatic send_box(input box_req_t b);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 6);
        end
        burst_left--;
        if (gap > 0)
        begin
            box_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        box_if.valid <= 1'b1;
        box_if.data  <= b;
        do @(posedge clk); while (!box_if.ready);
    endtask

    // Hold the box side and wait until every owed result has come out
    task automatic drain_results();
        box_if.valid <= 1'b0;
        @(negedge clk);
        wait (results_pending == 0);
        @(posedge clk);
    endtask

    task automatic write_tolerance(input int t);
        drain_results();
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= cfg_req_t'(TOL_W'(t));
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    // Stacking sequences of random length, some long enough to fill the store
    task automatic run_pallets(input int n_items);
        int left;
        int len;
        left = n_items;
        while (left > 0)
        begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(33, 40) : $urandom_range(2, 16);
            for (int i = 0; i < len && left > 0; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_box(noise_box());
                else
                    send_box(pallet_box(i == 0));
                left--;
            end
        end
    endtask

    // Pile large overlapping boxes on one pallet to fill the store and raise the total
    task automatic pile_boxes();
        for (int i = 0; i < PILE_BOXES; i++)
            send_box(mk_box(i == 0, int'($urandom_range(0, 10)) - 5,
                            int'($urandom_range(0, 10)) - 5,
                            int'($urandom_range(495, 505)),
                            800 + int'($urandom_range(0, 10)),
                            800 + int'($urandom_range(0, 10)),
                            800 + int'($urandom_range(0, 10)),
                            $urandom_range(1, 24), $urandom_range(0, 65535)));
    endtask

    initial
    begin
        int tol_plan [6];
        tol_plan = '{255, 0, -1, 1, 254, -1};

        rst_n        = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = '0;
        box_if.valid = 1'b0;
        box_if.data  = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests under the reset tolerance
        send_box(mk_box(1, 0, 0, 100, 200, 100, 100, 1, 0));       // seq zero, resting on pallet
        send_box(mk_box(0, 0, 0, 100, 200, 100, 100, 2, 1));       // same spot, hits seq zero
        send_box(mk_box(0, 150, 0, 100, 100, 100, 100, 1, 2));     // face to face in X
        send_box(mk_box(0, 0, 0, 200, 100, 100, 100, 1, 3));       // resting on top
        send_box(mk_box(0, 0, 0, 50, 100, 100, 100, 5, 4));        // sunk into the pallet
        send_box(mk_box(0, 20, 20, 120, 300, 80, 60, 6, 5));
        send_box(mk_box(0, -20, 10, 90, 90, 70, 50, 9, 6));
        send_box(mk_box(0, 10, -10, 80, 60, 40, 30, 10, 7));
        send_box(mk_box(0, 5, 5, 60, 40, 40, 40, 24, 8));
        send_box(mk_box(0, 0, 0, 100, 10, 10, 10, 13, 9));
        send_box(mk_box(0, 0, 0, 100, 10, 10, 10, 0, 10));         // bad orientation codes
        send_box(mk_box(0, 0, 0, 100, 10, 10, 10, 25, 11));
        send_box(mk_box(0, 0, 0, 100, 10, 10, 10, 31, 12));
        send_box(mk_box(0, -32768, -32768, -32768, 32767, 32767, 32767, 3, 65535));
        send_box(mk_box(0, 32767, 32767, 32767, 0, 0, 0, 4, 65534));
        send_box(mk_box(0, 32767, -32768, 0, 32767, 0, 32767, 7, 16'hAAAA));
        send_box(mk_box(1, 0, 0, 0, 1, 1, 1, 30, 16'h5555));       // bad code clears the pallet
        send_box(mk_box(1, -1, -1, -1, 32767, 16384, 1, 12, 1));
        send_box(mk_box(0, -1, -1, -1, 32767, 16384, 1, 11, 2));
        send_box(mk_box(0, 0, 0, 100, 200, 100, 100, 8, 3));

        // Random stacking under a range of tolerances
        foreach (tol_plan[p])
        begin
            write_tolerance((tol_plan[p] < 0) ? $urandom_range(2, 253) : tol_plan[p]);
            run_pallets(PHASE_ITEMS);
        end

        write_tolerance($urandom_range(0, 255));
        pile_boxes();

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/pbcc_pkg.sv
hw/rtl/pbcc_stream_if.sv
hw/rtl/pbcc_ctrl.sv
hw/rtl/pbcc_dp.sv
hw/rtl/placed_box_collision_check.sv
sim/pbcc_collision_monitor.sv
sim/placed_box_collision_check_tb.sv
